>>> src/tlgs_pkg.sv
// Shared types and constants of the toroidal life generation step block.
package tlgs_pkg;

    localparam int GRID_COLS = 256;
    localparam int GRID_ROWS = 128;

    localparam int COL_W  = $clog2(GRID_COLS);
    localparam int ROW_W  = $clog2(GRID_ROWS);
    localparam int CCFG_W = 9;
    localparam int RCFG_W = 8;
    localparam int CIDX_W = 2;
    localparam int CDAT_W = 9;
    localparam int MIN_SIZE = 3;

    localparam logic [CIDX_W-1:0] CFG_COLS   = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_ROWS   = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_PAUSED = 2'd2;

    localparam logic [CCFG_W-1:0] COLS_RESET = 9'd160;
    localparam logic [RCFG_W-1:0] ROWS_RESET = 8'd90;

    typedef logic [GRID_COLS-1:0] t_row;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_GEN   = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CELL,
        ST_GEN_LAST,
        ST_GEN_FIRST,
        ST_GEN_ROW,
        ST_PUT
    } t_state;

    typedef struct packed {
        logic             rd_en;
        logic [ROW_W-1:0] rd_addr;
        logic             wr_en;
        logic [ROW_W-1:0] wr_addr;
        t_row             wr_data;
    } t_mem_req;

endpackage

>>> src/tlgs_if.sv
// Request and response channel interfaces of the life block.
interface tlgs_req_if;
    import tlgs_pkg::*;
    logic             valid;
    logic             ready;
    logic [1:0]       opcode;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             cell_in;

    modport source (output valid, opcode, col, row, cell_in, input ready);
    modport sink   (input valid, opcode, col, row, cell_in, output ready);
endinterface

interface tlgs_rsp_if;
    logic valid;
    logic ready;
    logic cell_out;
    logic generation_done;

    modport source (output valid, cell_out, generation_done, input ready);
    modport sink   (input valid, cell_out, generation_done, output ready);
endinterface

>>> src/toroidal_life_generation_step.sv
// Top level of the toroidal life block: sequencer, configuration and result register.
//
//  channel      dir  fields                              handshake
//  i_cell_req   in   opcode, col, row, cell_in           valid/ready
//  o_cell_rsp   out  cell_out, generation_done           valid/ready
//  i_cfg_*      in   i_cfg_idx, i_cfg_data               i_cfg_we, no wait
//
//  Write and read requests inside the active area pass through accept, row read and
//  result load; all other requests except a running generation pass accept and result load.
//  A generation makes one row-wide memory access pair per row.
//  Reset clears the per-row valid bits at once; no clearing pass is needed.
//  A new request is taken while the previous result still waits in the output register.
module toroidal_life_generation_step (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    tlgs_req_if.sink                    i_cell_req,
    tlgs_rsp_if.source                  o_cell_rsp,
    input  logic                        i_cfg_we,
    input  logic [tlgs_pkg::CIDX_W-1:0] i_cfg_idx,
    input  logic [tlgs_pkg::CDAT_W-1:0] i_cfg_data
);
    import tlgs_pkg::*;

    t_state            r_state, n_state;
    t_op               r_op;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic              r_cell_in;
    t_row              r_prev, r_cur, r_first;
    logic [ROW_W-1:0]  r_gen_row;
    logic              r_res_cell, r_res_done;
    logic              r_out_vld, r_out_cell, r_out_done;
    logic [CCFG_W-1:0] r_cols_cfg;
    logic [RCFG_W-1:0] r_rows_cfg;
    logic              r_paused;

    logic [CCFG_W-1:0] cols_eff;
    logic [RCFG_W-1:0] rows_eff;
    logic [ROW_W-1:0]  row_last;
    logic              req_inside;
    t_op               req_op;
    logic              accept;
    logic              out_free;
    logic              last_row;
    t_mem_req          mem_req;
    t_row              rd_row;
    t_row              next_row;
    t_row              calc_row;
    t_row              patched_row;

    assign cols_eff = (r_cols_cfg < CCFG_W'(MIN_SIZE)) ? CCFG_W'(MIN_SIZE) :
                      (r_cols_cfg > CCFG_W'(GRID_COLS)) ? CCFG_W'(GRID_COLS) : r_cols_cfg;
    assign rows_eff = (r_rows_cfg < RCFG_W'(MIN_SIZE)) ? RCFG_W'(MIN_SIZE) :
                      (r_rows_cfg > RCFG_W'(GRID_ROWS)) ? RCFG_W'(GRID_ROWS) : r_rows_cfg;
    assign row_last = ROW_W'(rows_eff - RCFG_W'(1));

    assign req_op     = t_op'(i_cell_req.opcode);
    assign req_inside = (CCFG_W'(i_cell_req.col) < cols_eff)
                     && (RCFG_W'(i_cell_req.row) < rows_eff);
    assign accept     = i_cell_req.valid && i_cell_req.ready;
    assign out_free   = !r_out_vld || o_cell_rsp.ready;
    assign last_row   = (r_gen_row == row_last);
    // the row after the last wraps to the saved original first row
    assign next_row   = last_row ? r_first : rd_row;

    tlgs_row_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rd_row(rd_row)
    );

    tlgs_row_calc u_calc (
        .i_prev(r_prev),
        .i_cur (r_cur),
        .i_next(next_row),
        .i_cols(cols_eff),
        .o_row (calc_row)
    );

    always_comb begin
        patched_row        = rd_row;
        patched_row[r_col] = r_cell_in;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    priority if ((req_op == OP_WRITE || req_op == OP_READ) && req_inside)
                        n_state = ST_CELL;
                    else if (req_op == OP_GEN && !r_paused)
                        n_state = ST_GEN_LAST;
                    else
                        n_state = ST_PUT;
                end
            end
            ST_CELL:      n_state = ST_PUT;
            ST_GEN_LAST:  n_state = ST_GEN_FIRST;
            ST_GEN_FIRST: n_state = ST_GEN_ROW;
            ST_GEN_ROW: begin
                if (last_row) n_state = ST_PUT;
            end
            ST_PUT: begin
                if (out_free) n_state = ST_IDLE;
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        i_cell_req.ready = 1'b0;
        mem_req          = '0;
        unique case (r_state)
            ST_IDLE: begin
                i_cell_req.ready = 1'b1;
                mem_req.rd_en    = accept;
                mem_req.rd_addr  = (req_op == OP_GEN) ? row_last : i_cell_req.row;
            end
            ST_CELL: begin
                mem_req.wr_en   = (r_op == OP_WRITE);
                mem_req.wr_addr = r_row;
                mem_req.wr_data = patched_row;
            end
            ST_GEN_LAST: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = '0;
            end
            ST_GEN_FIRST: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = ROW_W'(1);
            end
            ST_GEN_ROW: begin
                // fetch two rows ahead while writing back this one
                mem_req.rd_en   = !last_row;
                mem_req.rd_addr = ROW_W'(r_gen_row + ROW_W'(2));
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = r_gen_row;
                mem_req.wr_data = calc_row;
            end
            ST_PUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_out_vld  <= 1'b0;
            r_cols_cfg <= COLS_RESET;
            r_rows_cfg <= ROWS_RESET;
            r_paused   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_PUT && out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_cell_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_COLS:   r_cols_cfg <= i_cfg_data[CCFG_W-1:0];
                    CFG_ROWS:   r_rows_cfg <= i_cfg_data[RCFG_W-1:0];
                    CFG_PAUSED: r_paused   <= i_cfg_data[0];
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_op       <= req_op;
                r_col      <= i_cell_req.col;
                r_row      <= i_cell_req.row;
                r_cell_in  <= i_cell_req.cell_in;
                r_res_cell <= 1'b0;
                r_res_done <= 1'b0;
            end
            ST_CELL: begin
                r_res_cell <= (r_op == OP_READ) && rd_row[r_col];
            end
            ST_GEN_LAST: begin
                r_prev <= rd_row;
            end
            ST_GEN_FIRST: begin
                r_cur     <= rd_row;
                r_first   <= rd_row;
                r_gen_row <= '0;
            end
            ST_GEN_ROW: begin
                r_prev     <= r_cur;
                r_cur      <= next_row;
                r_gen_row  <= ROW_W'(r_gen_row + ROW_W'(1));
                r_res_done <= last_row;
            end
            ST_PUT: begin
                if (out_free) begin
                    r_out_cell <= r_res_cell;
                    r_out_done <= r_res_done;
                end
            end
            default: ;
        endcase
    end

    assign o_cell_rsp.valid           = r_out_vld;
    assign o_cell_rsp.cell_out        = r_out_cell;
    assign o_cell_rsp.generation_done = r_out_done;

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_PUT) |-> !mem_req.wr_en)
        else $error("grid memory written outside an operation");

    a_gen_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GEN_ROW) |-> (r_gen_row <= row_last))
        else $error("generation row beyond active rows");

    a_gen_done_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GEN_ROW && last_row) |=> (r_state == ST_PUT && r_res_done))
        else $error("finished generation not flagged");

    a_result_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PUT) |-> !(r_res_cell && r_res_done))
        else $error("read value and generation flag both set");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GEN_ROW || r_state == ST_CELL) |-> !i_cell_req.ready)
        else $error("request taken while an operation is in flight");

endmodule

>>> src/tlgs_row_mem.sv
// Row-wide grid memory with per-row valid bits; an unwritten row reads as dead.
module tlgs_row_mem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tlgs_pkg::t_mem_req i_req,
    output tlgs_pkg::t_row    o_rd_row
);
    import tlgs_pkg::*;

    t_row                 mem [GRID_ROWS];
    logic [GRID_ROWS-1:0] r_row_vld;
    t_row                 r_rd_data;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_row_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_row_vld[i_req.rd_addr];
            end
        end
    end

    assign o_rd_row = r_rd_vld ? r_rd_data : '0;

endmodule

>>> src/tlgs_row_calc.sv
// One row of the B3/S23 update, one lane per column, wrapping at the active width.
module tlgs_row_calc (
    input  tlgs_pkg::t_row                 i_prev,
    input  tlgs_pkg::t_row                 i_cur,
    input  tlgs_pkg::t_row                 i_next,
    input  logic [tlgs_pkg::CCFG_W-1:0]    i_cols,
    output tlgs_pkg::t_row                 o_row
);
    import tlgs_pkg::*;

    logic [COL_W-1:0] col_last;
    logic             prev_edge;
    logic             cur_edge;
    logic             next_edge;

    assign col_last  = COL_W'(i_cols - CCFG_W'(1));
    assign prev_edge = i_prev[col_last];
    assign cur_edge  = i_cur[col_last];
    assign next_edge = i_next[col_last];

    for (genvar c = 0; c < GRID_COLS; c++) begin : g_lane
        logic       pl, cl, nl, pr, cr, nr;
        logic [3:0] count;
        logic       rule;

        if (c == 0) begin : g_left_wrap
            assign pl = prev_edge;
            assign cl = cur_edge;
            assign nl = next_edge;
        end else begin : g_left
            assign pl = i_prev[c-1];
            assign cl = i_cur[c-1];
            assign nl = i_next[c-1];
        end

        if (c == GRID_COLS - 1) begin : g_right_wrap
            assign pr = i_prev[0];
            assign cr = i_cur[0];
            assign nr = i_next[0];
        end else begin : g_right
            logic is_last;

            assign is_last = (col_last == COL_W'(c));
            assign pr = is_last ? i_prev[0] : i_prev[c+1];
            assign cr = is_last ? i_cur[0]  : i_cur[c+1];
            assign nr = is_last ? i_next[0] : i_next[c+1];
        end

        assign count = 4'(pl) + 4'(i_prev[c]) + 4'(pr) + 4'(cl) + 4'(cr)
                     + 4'(nl) + 4'(i_next[c]) + 4'(nr);
        assign rule  = (count == 4'd3) || (i_cur[c] && (count == 4'd2));
        // columns beyond the active width keep their value
        assign o_row[c] = (CCFG_W'(c) < i_cols) ? rule : i_cur[c];
    end

endmodule
